>>> hw/rtl/psiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psiq_pkg
// Shared types and constants for the positional insert shift queue.
// ----------------------------------------------------------------------------
package psiq_pkg;

  // Default number of slots in the queue.
  localparam int unsigned DEFAULT_DEPTH = 16;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned NAME_W = 8;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned OCC_W  = 5;

  // Operation codes on the request channel.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_INSERT = 2'd2,
    OP_NOP    = 2'd3
  } psiq_op_t;

  // Status codes on the response channel.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } psiq_status_t;

  // Control broadcast from the top level to every slot cell.
  typedef struct packed {
    logic              ins;   // Insert: cells at or above the index move up.
    logic              del;   // Delete head: every cell takes its upper neighbor.
    logic [NAME_W-1:0] name;  // Name loaded into the cell at the insert index.
  } psiq_ctl_t;

endpackage

>>> hw/rtl/psiq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psiq_req_if / psiq_rsp_if
// Valid/ready channels for queue requests and queue responses.
// ----------------------------------------------------------------------------
interface psiq_req_if
  import psiq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [NAME_W-1:0] name_byte;
  logic [POS_W-1:0]  position;

  modport source (output valid, output operation, output name_byte, output position,
                  input ready);
  modport sink   (input valid, input operation, input name_byte, input position,
                  output ready);
endinterface

interface psiq_rsp_if
  import psiq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [OCC_W-1:0]  occupancy;
  logic              head_valid;
  logic [NAME_W-1:0] head_name;

  modport source (output valid, output status, output occupancy, output head_valid,
                  output head_name, input ready);
  modport sink   (input valid, input status, input occupancy, input head_valid,
                  input head_name, output ready);
endinterface

>>> hw/rtl/psiq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psiq_cell
// One queue slot: holds, loads a new name, or takes a neighbor's name.
// ----------------------------------------------------------------------------
module psiq_cell
  import psiq_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  logic              clk,
  input  psiq_ctl_t         ctl,
  input  logic [IW-1:0]     ins_idx,
  input  logic [NAME_W-1:0] lower_val,
  input  logic [NAME_W-1:0] upper_val,
  output logic [NAME_W-1:0] val
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [NAME_W-1:0] val_next;

  // Pick the next slot content from the broadcast control.
  always_comb begin
    val_next = val;
    if (ctl.ins) begin
      if (MY_IDX > ins_idx) begin
        val_next = lower_val;
      end else if (MY_IDX == ins_idx) begin
        val_next = ctl.name;
      end
    end else if (ctl.del) begin
      val_next = upper_val;
    end
  end

  // Slot storage carries payload only and needs no reset.
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

>>> hw/rtl/positional_insert_shift_queue_top.sv
`timescale 1ns / 1ps
// Response: offered in the cycle after its request transaction is accepted.
// Throughput: one request per cycle while responses are taken at once; a response
// that waits holds off the next request until it is taken.
// Reset: synchronous rst empties the queue (count zero) and drops any pending
// response; slot contents are left as they are and are never read while empty.
// ----------------------------------------------------------------------------
// positional_insert_shift_queue_top
// Fixed-depth name queue built from a chain of slot cells with positional insert.
// ----------------------------------------------------------------------------
module positional_insert_shift_queue_top
  import psiq_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  psiq_req_if.sink    req,
  psiq_rsp_if.source  rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              rsp_valid;
  psiq_status_t      status;
  psiq_status_t      status_next;
  psiq_ctl_t         ctl;
  logic [IW-1:0]     ins_idx;
  logic              accept;
  logic              full;
  logic              empty;
  logic [POS_W-1:0]  pos_m1;
  logic [31:0]       pos_ext;
  logic [31:0]       cnt_ext;
  logic [31:0]       sel_ext;
  logic [NAME_W-1:0] slot_val [DEPTH];

  assign accept    = req.valid & req.ready;
  assign req.ready = ~rsp_valid | rsp.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  // Insert index: position zero maps to the head, anything past the tail appends.
  assign pos_m1  = (req.position == '0) ? '0 : req.position - POS_W'(1);
  assign pos_ext = 32'(pos_m1);
  assign cnt_ext = 32'(count);
  assign sel_ext = (req.operation == OP_APPEND || pos_ext > cnt_ext) ? cnt_ext : pos_ext;
  assign ins_idx = sel_ext[IW-1:0];

  // Decode the request into the cell control and the new count.
  always_comb begin
    ctl.ins     = 1'b0;
    ctl.del     = 1'b0;
    ctl.name    = req.name_byte;
    count_next  = count;
    status_next = ST_DONE;
    case (psiq_op_t'(req.operation))
      OP_APPEND, OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.del    = accept;
          count_next = count - CW'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Chain of slot cells; each cell sees both neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [NAME_W-1:0] lower;
    logic [NAME_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = slot_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = slot_val[i+1];
    end
    psiq_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_idx   (ins_idx),
      .lower_val (lower),
      .upper_val (upper),
      .val       (slot_val[i])
    );
  end

  // Count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
      status    <= ST_DONE;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
        status    <= status_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // State changes only on an accepted request, so the response reads it live.
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = status;
  assign rsp.occupancy  = cnt_ext[OCC_W-1:0];
  assign rsp.head_valid = ~empty;
  assign rsp.head_name  = empty ? '0 : slot_val[0];

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the positional insert shift queue. A table of
// directed requests covers the empty and full queue, position zero, positions
// past the tail and the unused operation code. Random requests follow; they
// drift between filling and draining the queue. A shadow copy of the queue
// predicts every response, and each response is compared field by field.
// Both channels idle at random in several phases.
// ----------------------------------------------------------------------------
module testbench;
  import psiq_pkg::*;

  localparam int QDEPTH           = DEFAULT_DEPTH;
  localparam int STALL_LIMIT      = 4000;
  localparam int ITEMS_PER_PHASE  = 188;
  localparam int DRAIN_CYCLES     = 10;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int NUM_PHASES       = 4;
  localparam int NUM_DIRECTED     = 24;

  // One response as the queue reports it.
  typedef struct packed {
    psiq_status_t      status;
    logic [OCC_W-1:0]  occupancy;
    logic              head_valid;
    logic [NAME_W-1:0] head_name;
  } queue_resp_t;

  // One directed request; typed rows carry their own expected response.
  typedef struct packed {
    psiq_op_t          op;
    logic [NAME_W-1:0] name;
    logic [POS_W-1:0]  pos;
    logic              typed;
    queue_resp_t       resp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  psiq_req_if req_ch ();
  psiq_rsp_if rsp_ch ();

  positional_insert_shift_queue_top #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue contents.
  logic [NAME_W-1:0] shadow_names [QDEPTH];
  int                shadow_count = 0;

  queue_resp_t awaited_responses [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          src_idle_pct;
  int          sink_stall_pct;
  bit          fill_mode;

  // Expected response attached to the request currently on the channel.
  logic        row_typed;
  queue_resp_t row_resp;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_DELETE, 8'h00, 5'd0,  1'b1, '{ST_EMPTY, 5'd0, 1'b0, 8'h00}},
    '{OP_NOP,    8'hFF, 5'd31, 1'b1, '{ST_DONE,  5'd0, 1'b0, 8'h00}},
    '{OP_APPEND, 8'hFF, 5'd0,  1'b1, '{ST_DONE,  5'd1, 1'b1, 8'hFF}},
    '{OP_INSERT, 8'h00, 5'd0,  1'b1, '{ST_DONE,  5'd2, 1'b1, 8'h00}},
    '{OP_INSERT, 8'h55, 5'd31, 1'b0, '0},
    '{OP_INSERT, 8'hA5, 5'd1,  1'b0, '0},
    '{OP_APPEND, 8'h5A, 5'd0,  1'b0, '0},
    '{OP_INSERT, 8'h01, 5'd16, 1'b0, '0},
    '{OP_INSERT, 8'h80, 5'd3,  1'b0, '0},
    '{OP_INSERT, 8'h7F, 5'd2,  1'b0, '0},
    '{OP_APPEND, 8'h02, 5'd0,  1'b0, '0},
    '{OP_INSERT, 8'h04, 5'd6,  1'b0, '0},
    '{OP_INSERT, 8'h08, 5'd8,  1'b0, '0},
    '{OP_INSERT, 8'h10, 5'd10, 1'b0, '0},
    '{OP_APPEND, 8'h20, 5'd0,  1'b0, '0},
    '{OP_INSERT, 8'h40, 5'd13, 1'b0, '0},
    '{OP_INSERT, 8'h3C, 5'd15, 1'b0, '0},
    '{OP_INSERT, 8'hC3, 5'd16, 1'b0, '0},
    '{OP_APPEND, 8'hEE, 5'd0,  1'b0, '0},
    '{OP_INSERT, 8'h11, 5'd0,  1'b0, '0},
    '{OP_NOP,    8'h00, 5'd0,  1'b0, '0},
    '{OP_DELETE, 8'hFF, 5'd31, 1'b0, '0},
    '{OP_INSERT, 8'h99, 5'd16, 1'b0, '0},
    '{OP_DELETE, 8'h00, 5'd0,  1'b0, '0}
  };

  // Apply one request to the shadow queue and return the response it yields.
  function automatic queue_resp_t next_queue_resp(psiq_op_t op, logic [NAME_W-1:0] nm,
                                                  logic [POS_W-1:0] pos);
    queue_resp_t r;
    int          slot;
    int          i;
    r.status = ST_DONE;
    case (op)
      OP_APPEND, OP_INSERT: begin
        if (shadow_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Position zero means the head; anything past the tail appends.
          slot = (op == OP_APPEND) ? shadow_count : ((pos == 0) ? 0 : int'(pos) - 1);
          if (slot > shadow_count) slot = shadow_count;
          for (i = shadow_count; i > slot; i--) shadow_names[i] = shadow_names[i - 1];
          shadow_names[slot] = nm;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 1; i < shadow_count; i++) shadow_names[i - 1] = shadow_names[i];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.occupancy  = OCC_W'(shadow_count);
    r.head_valid = (shadow_count > 0);
    r.head_name  = (shadow_count > 0) ? shadow_names[0] : '0;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= SHOWN_MISMATCHES) $display("%s", msg);
  endfunction

  // Drive one request transaction; entered and left at a falling edge.
  task automatic send_request(psiq_op_t op, logic [NAME_W-1:0] nm, logic [POS_W-1:0] pos,
                              logic typed, queue_resp_t resp);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.name_byte <= nm;
    req_ch.position  <= pos;
    row_typed        <= typed;
    row_resp         <= resp;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Random request that leans toward filling or draining the queue.
  task automatic send_random_request();
    psiq_op_t          op;
    logic [NAME_W-1:0] nm;
    logic [POS_W-1:0]  pos;
    int                roll;
    if (shadow_count >= QDEPTH && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
    if (shadow_count == 0) fill_mode = 1'b1;
    if ($urandom_range(0, 99) < 3) fill_mode = !fill_mode;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      op = OP_NOP;
    end else if ((roll < 64) == fill_mode) begin
      op = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
    end else begin
      op = OP_DELETE;
    end
    nm = NAME_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) begin
      pos = POS_W'($urandom_range(0, shadow_count + 1));
    end else begin
      pos = POS_W'($urandom_range(0, 31));
    end
    send_request(op, nm, pos, 1'b0, '0);
  endtask

  // Receiver side: ready changes at the falling edge.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Predict on each accepted request, check each accepted response, and watch
  // for a channel that stops moving.
  always @(posedge clk) begin : response_check
    queue_resp_t predicted;
    queue_resp_t want;
    queue_resp_t got;
    logic        moved;
    if (!rst) begin
      moved = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        predicted = next_queue_resp(psiq_op_t'(req_ch.operation), req_ch.name_byte,
                                    req_ch.position);
        awaited_responses.push_back(row_typed ? row_resp : predicted);
        moved = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved = 1'b1;
        got = '{psiq_status_t'(rsp_ch.status), rsp_ch.occupancy, rsp_ch.head_valid,
                rsp_ch.head_name};
        if (awaited_responses.size() == 0) begin
          note_failure($sformatf("Unexpected response: status %0d occupancy %0d head %0b/%02h",
                                 got.status, got.occupancy, got.head_valid, got.head_name));
        end else begin
          want = awaited_responses.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"Response mismatch: expected status %0d occupancy %0d ",
                                    "head %0b/%02h, got status %0d occupancy %0d head %0b/%02h"},
                                   want.status, want.occupancy, want.head_valid,
                                   want.head_name, got.status, got.occupancy,
                                   got.head_valid, got.head_name));
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Reset, directed table, random phases with changing idle patterns, drain.
  initial begin : stimulus
    int phase;
    int n;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_NOP;
    req_ch.name_byte = '0;
    req_ch.position  = '0;
    row_typed        = 1'b0;
    row_resp         = '0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    fill_mode        = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].name, directed_rows[i].pos,
                   directed_rows[i].typed, directed_rows[i].resp);
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
        default: begin src_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_request();
    end
    req_ch.valid <= 1'b0;

    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_responses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/psiq_pkg.sv
hw/rtl/psiq_if.sv
hw/rtl/psiq_cell.sv
hw/rtl/positional_insert_shift_queue_top.sv
test/testbench.sv
